// ===== rtl/matrix_peak_climb_core_macros.svh =====
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef MATRIX_PEAK_CLIMB_CORE_MACROS_SVH
`define MATRIX_PEAK_CLIMB_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every edge out of reset
`define MPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be seen out of reset
`define MPC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MPC_ASSERT(label, clk, rst_n, prop, msg)
`define MPC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== rtl/mpc_pkg.sv =====
`default_nettype none

package mpc_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLS    = 64;
    localparam int VALUE_WIDTH = 32;

    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int SHAPE_W = 7;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Usable shape is bounded by the store and by the 6-bit coordinates
    localparam logic [SHAPE_W-1:0] ROW_CAP = SHAPE_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);
    localparam logic [SHAPE_W-1:0] COL_CAP = SHAPE_W'((MAX_COLS < 64) ? MAX_COLS : 64);

    // Scan slots: centre first, then the eight neighbours
    localparam int NB_COUNT = 9;
    localparam int IDX_W    = 4;
    localparam logic [IDX_W-1:0] SCAN_LAST_ISSUE = IDX_W'(NB_COUNT - 1);
    localparam logic [IDX_W-1:0] SCAN_LAST_CMP   = IDX_W'(NB_COUNT);
    localparam logic [IDX_W-1:0] SCAN_DECIDE     = IDX_W'(NB_COUNT + 1);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic STATUS_PEAK      = 1'b0;
    localparam logic STATUS_OUT_RANGE = 1'b1;

    localparam logic [1:0] STEP_HOLD = 2'b00;
    localparam logic [1:0] STEP_DEC  = 2'b01;
    localparam logic [1:0] STEP_INC  = 2'b10;

    typedef struct packed {
        logic                          op;
        logic [ROW_W-1:0]              row;
        logic [COL_W-1:0]              col;
        logic signed [VALUE_WIDTH-1:0] element_value;
    } mpc_req_t;

    typedef struct packed {
        logic [ROW_W-1:0]              peak_row;
        logic [COL_W-1:0]              peak_col;
        logic signed [VALUE_WIDTH-1:0] peak_value;
        logic                          status;
    } mpc_rsp_t;

    typedef struct packed {
        logic             write;
        logic             start;
        logic             issue;
        logic             compare;
        logic             move;
        logic             load_peak;
        logic             load_err;
        logic [IDX_W-1:0] idx;
    } mpc_cmd_t;

    typedef struct packed {
        logic start_ok;
        logic moved;
    } mpc_sts_t;

    function automatic logic [1:0] step_row(input logic [IDX_W-1:0] idx);
        logic [1:0] s;
        case (idx)
            4'd1, 4'd2, 4'd3: s = STEP_DEC;
            4'd6, 4'd7, 4'd8: s = STEP_INC;
            default:          s = STEP_HOLD;
        endcase
        return s;
    endfunction

    function automatic logic [1:0] step_col(input logic [IDX_W-1:0] idx);
        logic [1:0] s;
        case (idx)
            4'd1, 4'd4, 4'd6: s = STEP_DEC;
            4'd3, 4'd5, 4'd8: s = STEP_INC;
            default:          s = STEP_HOLD;
        endcase
        return s;
    endfunction

    function automatic logic [SHAPE_W-1:0] shape_limit(input logic [SHAPE_W-1:0] v,
                                                       input logic [SHAPE_W-1:0] cap);
        logic [SHAPE_W-1:0] r;
        if (v == '0)
            r = SHAPE_W'(1);
        else if (v > cap)
            r = cap;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c));
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mpc_ram.sv =====
`default_nettype none

module mpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/mpc_ctrl.sv =====
`default_nettype none
`include "matrix_peak_climb_core_macros.svh"

module mpc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_op,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire mpc_pkg::mpc_sts_t sts,
    output mpc_pkg::mpc_cmd_t      cmd
);

    import mpc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PEAK,
        ST_ERR
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd         = '0;
        cmd.idx     = cnt_reg;
        cmd.write   = accept && (in_op == OP_LOAD);
        cmd.start   = accept && (in_op == OP_START) && sts.start_ok;
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept && (in_op == OP_START))
                begin
                    state_next = sts.start_ok ? ST_SCAN : ST_ERR;
                end
            end
            ST_SCAN:
            begin
                cmd.issue   = (cnt_reg <= SCAN_LAST_ISSUE);
                cmd.compare = (cnt_reg != '0) && (cnt_reg <= SCAN_LAST_CMP);
                if (cnt_reg == SCAN_DECIDE)
                begin
                    cnt_next = '0;
                    if (sts.moved)
                        cmd.move = 1'b1;
                    else
                        state_next = ST_PEAK;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_PEAK:
            begin
                cmd.load_peak = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_ERR:
            begin
                cmd.load_err = out_free;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (cmd.load_peak || cmd.load_err) ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    `MPC_ASSERT(a_start_leaves_idle, clk, rst_n, (accept && in_op == OP_START) |=> (state_reg == ST_SCAN || state_reg == ST_ERR), "start request did not begin a search")
    `MPC_ASSERT_NEVER(a_scan_count_bound, clk, rst_n, (state_reg == ST_SCAN && cnt_reg > SCAN_DECIDE), "scan counter ran past decide slot")
    `MPC_ASSERT(a_result_source, clk, rst_n, $rose(out_valid_reg) |-> ($past(state_reg) == ST_PEAK || $past(state_reg) == ST_ERR), "result raised outside a result state")
    `MPC_ASSERT(a_no_write_in_scan, clk, rst_n, (state_reg == ST_SCAN) |-> !cmd.write, "store written during a climb")

endmodule

`default_nettype wire

// ===== rtl/mpc_dp.sv =====
`default_nettype none

module mpc_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire mpc_pkg::mpc_req_t               req,
    input  wire logic [mpc_pkg::SHAPE_W-1:0]     row_count,
    input  wire logic [mpc_pkg::SHAPE_W-1:0]     column_count,
    input  wire mpc_pkg::mpc_cmd_t               cmd,
    output mpc_pkg::mpc_sts_t                    sts,
    output mpc_pkg::mpc_rsp_t                    rsp
);

    import mpc_pkg::*;

    logic [SHAPE_W-1:0] rows_eff;
    logic [SHAPE_W-1:0] cols_eff;

    logic [ROW_W-1:0] cur_row_reg;
    logic [COL_W-1:0] cur_col_reg;
    logic [ROW_W-1:0] best_row_reg;
    logic [COL_W-1:0] best_col_reg;
    logic signed [VALUE_WIDTH-1:0] best_val_reg;
    logic             moved_reg;

    logic             pend_ok_reg;
    logic             pend_centre_reg;
    logic [ROW_W-1:0] pend_row_reg;
    logic [COL_W-1:0] pend_col_reg;

    mpc_rsp_t         rsp_reg;

    logic [1:0]       srow;
    logic [1:0]       scol;
    logic [ROW_W-1:0] nb_row;
    logic [COL_W-1:0] nb_col;
    logic             nb_ok;
    logic             load_ok;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic             greater;

    assign rows_eff = shape_limit(row_count, ROW_CAP);
    assign cols_eff = shape_limit(column_count, COL_CAP);

    assign sts.start_ok = ({1'b0, req.row} < rows_eff) && ({1'b0, req.col} < cols_eff);
    assign sts.moved    = moved_reg;

    assign load_ok = ({1'b0, req.row} < ROW_CAP) && ({1'b0, req.col} < COL_CAP);

    // Neighbour coordinates and edge clipping for the slot being issued
    always_comb
    begin
        srow   = step_row(cmd.idx);
        scol   = step_col(cmd.idx);
        nb_row = cur_row_reg;
        nb_col = cur_col_reg;
        nb_ok  = 1'b1;
        case (srow)
            STEP_DEC:
            begin
                nb_row = cur_row_reg - ROW_W'(1);
                nb_ok  = (cur_row_reg != '0);
            end
            STEP_INC:
            begin
                nb_row = cur_row_reg + ROW_W'(1);
                nb_ok  = ({1'b0, cur_row_reg} + SHAPE_W'(1) < rows_eff);
            end
            default:
            begin
                nb_row = cur_row_reg;
            end
        endcase
        case (scol)
            STEP_DEC:
            begin
                nb_col = cur_col_reg - COL_W'(1);
                nb_ok  = nb_ok && (cur_col_reg != '0);
            end
            STEP_INC:
            begin
                nb_col = cur_col_reg + COL_W'(1);
                nb_ok  = nb_ok && ({1'b0, cur_col_reg} + SHAPE_W'(1) < cols_eff);
            end
            default:
            begin
                nb_col = cur_col_reg;
            end
        endcase
    end

    mpc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.write && load_ok),
        .wr_addr (cell_addr(req.row, req.col)),
        .wr_data (req.element_value),
        .rd_en   (cmd.issue),
        .rd_addr (cell_addr(nb_row, nb_col)),
        .rd_data (rd_data)
    );

    assign greater = $signed(rd_data) > best_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            moved_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                cur_row_reg <= req.row;
                cur_col_reg <= req.col;
            end
            else if (cmd.move)
            begin
                cur_row_reg <= best_row_reg;
                cur_col_reg <= best_col_reg;
            end
            if (cmd.compare)
            begin
                if (pend_centre_reg)
                    moved_reg <= 1'b0;
                else if (pend_ok_reg && greater)
                    moved_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            pend_ok_reg     <= nb_ok;
            pend_centre_reg <= (cmd.idx == '0);
            pend_row_reg    <= nb_row;
            pend_col_reg    <= nb_col;
        end
        if (cmd.compare && (pend_centre_reg || (pend_ok_reg && greater)))
        begin
            best_val_reg <= $signed(rd_data);
            best_row_reg <= pend_row_reg;
            best_col_reg <= pend_col_reg;
        end
        if (cmd.load_peak)
        begin
            rsp_reg.peak_row   <= cur_row_reg;
            rsp_reg.peak_col   <= cur_col_reg;
            rsp_reg.peak_value <= best_val_reg;
            rsp_reg.status     <= STATUS_PEAK;
        end
        else if (cmd.load_err)
        begin
            rsp_reg.peak_row   <= '0;
            rsp_reg.peak_col   <= '0;
            rsp_reg.peak_value <= '0;
            rsp_reg.status     <= STATUS_OUT_RANGE;
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/matrix_peak_climb_core.sv =====
// Greedy-ascent peak finder over a stored signed matrix.
// Request channel (in_valid / in_stall / in_data): op LOAD writes one element
// into the 64x64 store, op START begins a climb from (row, col).
// Result channel (out_valid / out_stall / out_data): one result per START,
// none per LOAD. Status 1 flags a start outside the configured shape.
// Shape registers row_count / column_count sit on the APB port at 0x0 / 0x4.
// Stalls: a LOAD does not raise in_stall. A START holds in_stall high until done.
// Each climb step reads the centre plus 8 neighbours one per cycle through the
// single store read port, compares each registered read, then decides whether to move.
// Steps repeat until no neighbour is larger; an out-of-range start skips the climb.
// The result sits in an output register; loads are taken while it waits.
// A finished climb waits (in_stall high) if the previous result is unclaimed.
// Reset: shape registers go to 1x1, position to (0,0); the store is not
// cleared, so every cell a climb may visit must be loaded first.
`default_nettype none

module matrix_peak_climb_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire mpc_pkg::mpc_req_t             in_data,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output mpc_pkg::mpc_rsp_t                  out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mpc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mpc_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mpc_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);

    import mpc_pkg::*;

    logic [SHAPE_W-1:0] row_count_reg;
    logic [SHAPE_W-1:0] column_count_reg;
    logic               reg_sel;
    logic               cfg_write;
    mpc_cmd_t           cmd;
    mpc_sts_t           sts;

    // APB: zero wait states; register picked by word address bit
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= SHAPE_W'(1);
            column_count_reg <= SHAPE_W'(1);
        end
        else if (cfg_write)
        begin
            case (reg_sel)
                REG_ROW_COUNT:    row_count_reg    <= pwdata[SHAPE_W-1:0];
                REG_COLUMN_COUNT: column_count_reg <= pwdata[SHAPE_W-1:0];
                default:          row_count_reg    <= row_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ROW_COUNT:    prdata = PDATA_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = PDATA_W'(column_count_reg);
            default:          prdata = '0;
        endcase
    end

    // Sequencer: accepts requests, walks the scan slots, owns result valid
    mpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_op     (in_data.op),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Store, position, best-so-far tracking and result payload
    mpc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (in_data),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .cmd          (cmd),
        .sts          (sts),
        .rsp          (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/peak_climb_checker.sv =====
`timescale 1ns / 1ps

// Watches the request and result channels and the register port, keeps its own copy of
// the store and shape, climbs each start in software and compares.
module peak_climb_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire mpc_pkg::mpc_req_t             in_data,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire mpc_pkg::mpc_rsp_t             out_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [mpc_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mpc_pkg::PDATA_W-1:0]   pwdata,
    output int                                 mismatches,
    output int                                 pending_peaks
);
    import mpc_pkg::*;

    localparam logic [PADDR_W-1:0] ROW_COUNT_ADDR    = {REG_ROW_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] COLUMN_COUNT_ADDR = {REG_COLUMN_COUNT, 2'b00};
    localparam int ROW_LIMIT = (MAX_ROWS < (1 << ROW_W)) ? MAX_ROWS : (1 << ROW_W);
    localparam int COL_LIMIT = (MAX_COLS < (1 << COL_W)) ? MAX_COLS : (1 << COL_W);
    localparam int REPORT_CAP = 50;

    logic signed [VALUE_WIDTH-1:0] matrix_cells [MAX_ROWS][MAX_COLS];
    logic [SHAPE_W-1:0]            row_setting;
    logic [SHAPE_W-1:0]            column_setting;
    mpc_rsp_t                      expected_peaks [$];
    int                            fail_count;

    // zero reads as one, oversize clips to the store
    function automatic int usable_extent(input logic [SHAPE_W-1:0] setting, input int limit);
        int extent;
        if (setting == '0)
            extent = 1;
        else if (int'(setting) > limit)
            extent = limit;
        else
            extent = int'(setting);
        return extent;
    endfunction

    function automatic mpc_rsp_t climb_to_peak(input logic [ROW_W-1:0] start_row,
                                               input logic [COL_W-1:0] start_col);
        int rows, cols, r, c, dr, dc, nr, nc, next_r, next_c;
        logic signed [VALUE_WIDTH-1:0] best;
        bit moved;
        mpc_rsp_t res;
        rows = usable_extent(row_setting, ROW_LIMIT);
        cols = usable_extent(column_setting, COL_LIMIT);
        res  = '0;
        if (int'(start_row) >= rows || int'(start_col) >= cols) begin
            res.status = STATUS_OUT_RANGE;
            return res;
        end
        r = int'(start_row);
        c = int'(start_col);
        do begin
            best   = matrix_cells[r][c];
            next_r = r;
            next_c = c;
            moved  = 1'b0;
            // raster order over the 3x3 window; strictly larger wins, so ties keep the earliest
            for (dr = -1; dr <= 1; dr++) begin
                for (dc = -1; dc <= 1; dc++) begin
                    nr = r + dr;
                    nc = c + dc;
                    if ((dr != 0 || dc != 0) && nr >= 0 && nc >= 0 && nr < rows && nc < cols) begin
                        if (matrix_cells[nr][nc] > best) begin
                            best   = matrix_cells[nr][nc];
                            next_r = nr;
                            next_c = nc;
                            moved  = 1'b1;
                        end
                    end
                end
            end
            r = next_r;
            c = next_c;
        end while (moved);
        res.peak_row   = ROW_W'(r);
        res.peak_col   = COL_W'(c);
        res.peak_value = matrix_cells[r][c];
        res.status     = STATUS_PEAK;
        return res;
    endfunction

    task automatic flag_field(input string field, input logic signed [VALUE_WIDTH:0] want,
                              input logic signed [VALUE_WIDTH:0] got);
        if (fail_count < REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        mpc_rsp_t want;
        if (!rst_n) begin
            row_setting    = SHAPE_W'(1);
            column_setting = SHAPE_W'(1);
            expected_peaks.delete();
            fail_count     = 0;
            mismatches    <= 0;
            pending_peaks <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_peaks.size() == 0) begin
                    if (fail_count < REPORT_CAP)
                        $display("%0t: result mismatch, expected none, actual %p", $time, out_data);
                    fail_count++;
                end
                else begin
                    want = expected_peaks.pop_front();
                    if (out_data.status !== want.status)
                        flag_field("status", want.status, out_data.status);
                    if (out_data.peak_row !== want.peak_row)
                        flag_field("peak_row", want.peak_row, out_data.peak_row);
                    if (out_data.peak_col !== want.peak_col)
                        flag_field("peak_col", want.peak_col, out_data.peak_col);
                    if (out_data.peak_value !== want.peak_value)
                        flag_field("peak_value", want.peak_value, out_data.peak_value);
                end
            end
            if (in_valid && !in_stall) begin
                if (in_data.op == OP_LOAD)
                    matrix_cells[in_data.row][in_data.col] = in_data.element_value;
                else
                    expected_peaks.push_back(climb_to_peak(in_data.row, in_data.col));
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ROW_COUNT_ADDR)
                    row_setting = pwdata[SHAPE_W-1:0];
                else if (paddr == COLUMN_COUNT_ADDR)
                    column_setting = pwdata[SHAPE_W-1:0];
            end
            mismatches    <= fail_count;
            pending_peaks <= expected_peaks.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

// Top of the bench: clock, reset, request stimulus, result back-pressure,
// shape register writes and the verdict. All prediction and comparison sits
// in peak_climb_checker, which reports a failure count and the number of
// peaks still owed by the block.
module testbench;
    import mpc_pkg::*;

    localparam logic [PADDR_W-1:0] ROW_COUNT_ADDR    = {REG_ROW_COUNT, 2'b00};
    localparam logic [PADDR_W-1:0] COLUMN_COUNT_ADDR = {REG_COLUMN_COUNT, 2'b00};
    // a ramp climb along a 64-row strip is ~64 steps; plenty of headroom
    localparam int IDLE_LIMIT    = 20000;
    // loads give no result, so allow the write pipe to drain before a register write
    localparam int SETTLE_CYCLES = 8;
    // whole-shape refill only when cheap; big shapes fill just the holes
    localparam int REFILL_CELLS  = 256;

    typedef enum int {VALUES_WIDE, VALUES_PLATEAU, VALUES_EXTREME, VALUES_RAMP} value_style_e;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    mpc_req_t              in_data;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    mpc_rsp_t              out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [PDATA_W-1:0]    pwdata;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending_peaks;

    // which store cells hold a value; a climb must never touch a hole
    bit                    loaded [MAX_ROWS][MAX_COLS];
    int                    row_extent = 1;
    int                    col_extent = 1;
    bit                    gaps_quiet = 1'b0;
    bit                    stall_quiet = 1'b0;
    int unsigned           stall_left = 0;
    int                    idle_cycles = 0;

    matrix_peak_climb_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    peak_climb_checker peak_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_data      (out_data),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .mismatches    (mismatches),
        .pending_peaks (pending_peaks)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result back-pressure: mostly short stalls, the odd long one, and
    // stretches with none at all (quiet mode flips now and then).
    always @(posedge clk)
    begin
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 299) == 0)
            stall_quiet = !stall_quiet;
        if (stall_left != 0)
            stall_left--;
        else if (!stall_quiet && roll >= 60)
            stall_left = (roll < 92) ? $urandom_range(1, 4) : $urandom_range(10, 60);
        out_stall <= (stall_left != 0);
    end

    // Watchdog: too long without any request, result or register access.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic int extent_of(input int raw);
        int e;
        if (raw == 0)
            e = 1;
        else if (raw > 64)
            e = 64;
        else
            e = raw;
        return e;
    endfunction

    function automatic int sender_gap();
        int unsigned roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (gaps_quiet || roll < 50)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 10);
        else
            gap = $urandom_range(20, 60);
        return gap;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_value(input value_style_e style,
                                                            input int r, input int c);
        logic [VALUE_WIDTH-1:0] v;
        int unsigned pick;
        pick = $urandom_range(0, 4);
        case (style)
            // -1..1: lots of ties between neighbours
            VALUES_PLATEAU: v = VALUE_WIDTH'($urandom_range(0, 2)) - VALUE_WIDTH'(1);
            VALUES_EXTREME:
            begin
                case (pick)
                    0:       v = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
                    1:       v = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = VALUE_WIDTH'(1);
                endcase
            end
            // rises towards the far corner, so climbs run long
            VALUES_RAMP: v = VALUE_WIDTH'((r + c) * 4 + $urandom_range(0, 3));
            default:     v = $urandom;
        endcase
        return v;
    endfunction

    // One request: optional idle gap, then hold valid and payload until taken.
    task automatic issue(input mpc_req_t req);
        int gap;
        gap = sender_gap();
        if ($urandom_range(0, 149) == 0)
            gaps_quiet = !gaps_quiet;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic load_cell(input int r, input int c, input logic [VALUE_WIDTH-1:0] value);
        mpc_req_t req;
        req.op            = OP_LOAD;
        req.row           = ROW_W'(r);
        req.col           = COL_W'(c);
        req.element_value = value;
        issue(req);
        loaded[r][c] = 1'b1;
    endtask

    // element_value is don't-care on a start, so it gets noise
    task automatic start_climb(input int r, input int c);
        mpc_req_t req;
        req.op            = OP_START;
        req.row           = ROW_W'(r);
        req.col           = COL_W'(c);
        req.element_value = $urandom;
        issue(req);
    endtask

    // Hold off the sender until the block owes no peaks.
    task automatic await_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_peaks != 0)
            @(posedge clk);
    endtask

    // Leaves psel high so a following write goes straight into its setup phase.
    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // Shape change only with the block idle.
    task automatic set_shape(input int rows_raw, input int cols_raw);
        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_write(ROW_COUNT_ADDR, PDATA_W'(rows_raw));
        apb_write(COLUMN_COUNT_ADDR, PDATA_W'(cols_raw));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        row_extent = extent_of(rows_raw);
        col_extent = extent_of(cols_raw);
    endtask

    task automatic fill_shape(input value_style_e style);
        int r, c;
        bit whole;
        whole = (row_extent * col_extent <= REFILL_CELLS);
        for (r = 0; r < row_extent; r++)
            for (c = 0; c < col_extent; c++)
                if (whole || !loaded[r][c])
                    load_cell(r, c, random_value(style, r, c));
    endtask

    // Random traffic over a fully loaded shape: rewrites inside it, stray
    // writes anywhere in the store, starts mostly inside, some anywhere.
    task automatic roam(input value_style_e style, input int count);
        int n, r, c;
        int unsigned pick;
        for (n = 0; n < count; n++)
        begin
            if (n == count / 2)
                await_results();
            pick = $urandom_range(0, 99);
            r    = $urandom_range(0, row_extent - 1);
            c    = $urandom_range(0, col_extent - 1);
            if (pick < 50)
                load_cell(r, c, random_value(style, r, c));
            else if (pick < 60)
                load_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else if (pick < 88)
                start_climb(r, c);
            else
                start_climb($urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: 1x1 out of reset, a lone cell is its own peak.
        // Far corner written outside the shape, then started on (both coords out).
        load_cell(0, 0, {1'b0, {(VALUE_WIDTH-1){1'b1}}});
        load_cell(63, 63, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
        start_climb(0, 0);
        start_climb(63, 63);

        // Zero row count reads as one row: 1x3 strip, equal pair beside a minimum.
        set_shape(0, 3);
        load_cell(0, 0, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
        load_cell(0, 1, '0);
        load_cell(0, 2, '0);
        start_climb(0, 0);
        start_climb(0, 2);
        start_climb(0, 3);

        // 3x3 dip in a flat plateau: the first neighbour in scan order wins,
        // and a plateau cell stays put because equal is not larger.
        set_shape(3, 3);
        load_cell(0, 0, VALUE_WIDTH'(7));
        load_cell(0, 1, VALUE_WIDTH'(7));
        load_cell(0, 2, VALUE_WIDTH'(7));
        load_cell(1, 0, VALUE_WIDTH'(7));
        load_cell(1, 1, '1);
        load_cell(1, 2, VALUE_WIDTH'(7));
        load_cell(2, 0, VALUE_WIDTH'(7));
        load_cell(2, 1, VALUE_WIDTH'(7));
        load_cell(2, 2, VALUE_WIDTH'(7));
        start_climb(1, 1);
        start_climb(2, 2);
        start_climb(3, 1);
        start_climb(2, 3);

        // Random phases across shapes, including one-row, one-column,
        // zero and oversize settings.
        set_shape(2, 2);
        fill_shape(VALUES_WIDE);
        roam(VALUES_WIDE, 60);

        set_shape(1, 64);
        fill_shape(VALUES_PLATEAU);
        roam(VALUES_PLATEAU, 60);

        set_shape(64, 1);
        fill_shape(VALUES_RAMP);
        roam(VALUES_RAMP, 60);

        set_shape(5, 7);
        fill_shape(VALUES_EXTREME);
        roam(VALUES_EXTREME, 60);

        set_shape(0, 0);
        fill_shape(VALUES_WIDE);
        roam(VALUES_WIDE, 60);

        set_shape(6, 6);
        fill_shape(VALUES_RAMP);
        roam(VALUES_RAMP, 60);

        // oversize rows: clipped to the full store height, two columns of ramp
        set_shape(127, 2);
        fill_shape(VALUES_RAMP);
        roam(VALUES_WIDE, 60);

        set_shape(8, 4);
        fill_shape(VALUES_PLATEAU);
        roam(VALUES_PLATEAU, 60);

        // oversize columns: clipped to the full store width
        set_shape(2, 100);
        fill_shape(VALUES_EXTREME);
        roam(VALUES_EXTREME, 60);

        set_shape(3, 20);
        fill_shape(VALUES_WIDE);
        roam(VALUES_WIDE, 60);

        set_shape(9, 9);
        fill_shape(VALUES_RAMP);
        roam(VALUES_RAMP, 60);

        set_shape(1, 1);
        roam(VALUES_WIDE, 60);

        await_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_peaks == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mpc_pkg.sv
rtl/mpc_ram.sv
rtl/mpc_ctrl.sv
rtl/mpc_dp.sv
rtl/matrix_peak_climb_core.sv
tb/peak_climb_checker.sv
tb/testbench.sv
